[sv/sobm_pkg.sv]
`timescale 1ns / 1ps
package sobm_pkg;

    localparam int LINE_DEPTH = 256;
    localparam int COL_W      = $clog2(LINE_DEPTH);
    localparam int CFG_W      = 9;
    localparam int ROW_W      = 9;
    localparam int PIX_W      = 8;
    localparam int GRAD_W     = 11;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [CFG_W-1:0] W_MAX = CFG_W'(LINE_DEPTH);
    localparam logic [CFG_W-1:0] H_MAX = CFG_W'(256);

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    localparam logic CFG_LINE_LEN   = 1'b0;
    localparam logic CFG_FRAME_ROWS = 1'b1;

    typedef struct packed {
        logic             kind;
        logic [PIX_W-1:0] pix_val;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] edge_magnitude;
        logic [7:0] out_column;
        logic [7:0] out_row;
        logic       frame_done;
    } t_out_beat;

    // one window column: top, mid, bottom
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } t_col;

    typedef struct packed {
        logic             has_row1;
        logic             has_row2;
        logic             flushing;
        logic             row_end;
        logic [COL_W-1:0] col;
        logic [7:0]       out_row;
        logic [PIX_W-1:0] pixel;
    } t_s1_item;

    typedef struct packed {
        logic             en;
        logic [COL_W-1:0] addr;
        logic [PIX_W-1:0] older;
        logic [PIX_W-1:0] newer;
    } t_line_wr;

    typedef struct packed {
        logic      v0;
        logic      v1;
        t_out_beat beat0;
        t_out_beat beat1;
    } t_push;

    function automatic logic [9:0] weigh_121(input logic [PIX_W-1:0] a,
                                             input logic [PIX_W-1:0] b,
                                             input logic [PIX_W-1:0] c);
        return 10'(a) + {1'b0, b, 1'b0} + 10'(c);
    endfunction

    function automatic logic signed [GRAD_W-1:0] grad_x(input t_col l, input t_col r);
        logic [9:0] sl;
        logic [9:0] sr;
        sl = weigh_121(l.top, l.mid, l.bot);
        sr = weigh_121(r.top, r.mid, r.bot);
        return $signed({1'b0, sr}) - $signed({1'b0, sl});
    endfunction

    function automatic logic signed [GRAD_W-1:0] grad_y(input t_col l, input t_col m,
                                                        input t_col r);
        logic [9:0] st;
        logic [9:0] sb;
        st = weigh_121(l.top, m.top, r.top);
        sb = weigh_121(l.bot, m.bot, r.bot);
        return $signed({1'b0, st}) - $signed({1'b0, sb});
    endfunction

    function automatic logic [7:0] clamp_abs(input logic signed [GRAD_W-1:0] g);
        logic [GRAD_W-1:0] a;
        a = g[GRAD_W-1] ? GRAD_W'(-g) : GRAD_W'(g);
        return (a > GRAD_W'(255)) ? 8'd255 : a[7:0];
    endfunction

    function automatic logic [7:0] magnitude(input logic signed [GRAD_W-1:0] gx,
                                             input logic signed [GRAD_W-1:0] gy);
        logic [8:0] s;
        s = {1'b0, clamp_abs(gx)} + {1'b0, clamp_abs(gy)};
        return (s > 9'd255) ? 8'd255 : s[7:0];
    endfunction

endpackage

[sv/sobm_in_if.sv]
`timescale 1ns / 1ps
interface sobm_in_if;
    logic               valid;
    logic               ready;
    sobm_pkg::t_in_beat data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[sv/sobm_out_if.sv]
`timescale 1ns / 1ps
interface sobm_out_if;
    logic                valid;
    logic                ready;
    sobm_pkg::t_out_beat data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[sv/sobm_line_buf.sv]
`timescale 1ns / 1ps
module sobm_line_buf (
    input  logic                             i_clk,
    input  logic [sobm_pkg::COL_W-1:0]       i_rd_addr,
    input  sobm_pkg::t_line_wr               i_wr,
    output logic [sobm_pkg::PIX_W-1:0]       o_older,
    output logic [sobm_pkg::PIX_W-1:0]       o_newer
);

    logic [sobm_pkg::PIX_W-1:0] r_older_mem [sobm_pkg::LINE_DEPTH];
    logic [sobm_pkg::PIX_W-1:0] r_newer_mem [sobm_pkg::LINE_DEPTH];
    logic [sobm_pkg::PIX_W-1:0] r_older_q;
    logic [sobm_pkg::PIX_W-1:0] r_newer_q;
    logic [sobm_pkg::PIX_W-1:0] r_fwd_older;
    logic [sobm_pkg::PIX_W-1:0] r_fwd_newer;
    logic                       r_fwd_hit;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_older_mem[i_wr.addr] <= i_wr.older;
            r_newer_mem[i_wr.addr] <= i_wr.newer;
        end
        r_older_q <= r_older_mem[i_rd_addr];
        r_newer_q <= r_newer_mem[i_rd_addr];
        r_fwd_older <= i_wr.older;
        r_fwd_newer <= i_wr.newer;
    end

    // read and write of the same entry in one cycle: hand the new data over
    always_ff @(posedge i_clk) begin
        r_fwd_hit <= i_wr.en && (i_wr.addr == i_rd_addr);
    end

    assign o_older = r_fwd_hit ? r_fwd_older : r_older_q;
    assign o_newer = r_fwd_hit ? r_fwd_newer : r_newer_q;

endmodule

[sv/sobm_grad.sv]
`timescale 1ns / 1ps
module sobm_grad (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s1_valid,
    input  sobm_pkg::t_s1_item           i_s1,
    input  logic [sobm_pkg::PIX_W-1:0]   i_older,
    input  logic [sobm_pkg::PIX_W-1:0]   i_newer,
    output sobm_pkg::t_line_wr           o_wr,
    output sobm_pkg::t_push              o_push
);

    sobm_pkg::t_col r_win_l;
    sobm_pkg::t_col r_win_m;
    sobm_pkg::t_col cur;
    sobm_pkg::t_col zero_col;

    logic                                r_v0;
    logic                                r_v1;
    logic signed [sobm_pkg::GRAD_W-1:0]  r_gx0;
    logic signed [sobm_pkg::GRAD_W-1:0]  r_gy0;
    logic signed [sobm_pkg::GRAD_W-1:0]  r_gx1;
    logic signed [sobm_pkg::GRAD_W-1:0]  r_gy1;
    logic [7:0]                          r_col0;
    logic [7:0]                          r_col1;
    logic [7:0]                          r_row;
    logic                                r_done;
    logic                                n_v0;
    logic                                n_v1;

    always_comb begin
        cur.top  = i_s1.has_row2 ? i_older : '0;
        cur.mid  = i_s1.has_row1 ? i_newer : '0;
        cur.bot  = i_s1.flushing ? '0 : i_s1.pixel;
        zero_col = '0;
    end

    assign o_wr.en    = i_s1_valid && !i_s1.flushing;
    assign o_wr.addr  = i_s1.col;
    assign o_wr.older = cur.mid;
    assign o_wr.newer = i_s1.pixel;

    assign n_v0 = i_s1_valid && i_s1.has_row1 && (i_s1.col != '0);
    assign n_v1 = i_s1_valid && i_s1.has_row1 && i_s1.row_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_l <= '0;
            r_win_m <= '0;
            r_v0    <= 1'b0;
            r_v1    <= 1'b0;
        end else begin
            r_v0 <= n_v0;
            r_v1 <= n_v1;
            if (i_s1_valid) begin
                if (i_s1.row_end) begin
                    r_win_l <= '0;
                    r_win_m <= '0;
                end else begin
                    r_win_l <= r_win_m;
                    r_win_m <= cur;
                end
            end
        end
    end

    // lane 0: centered one column back; lane 1: row-end result, zero column right
    always_ff @(posedge i_clk) begin
        r_gx0  <= sobm_pkg::grad_x(r_win_l, cur);
        r_gy0  <= sobm_pkg::grad_y(r_win_l, r_win_m, cur);
        r_gx1  <= sobm_pkg::grad_x(r_win_m, zero_col);
        r_gy1  <= sobm_pkg::grad_y(r_win_m, cur, zero_col);
        r_col0 <= 8'(i_s1.col - 1'b1);
        r_col1 <= 8'(i_s1.col);
        r_row  <= i_s1.out_row;
        r_done <= i_s1.flushing;
    end

    always_comb begin
        o_push.v0                   = r_v0;
        o_push.v1                   = r_v1;
        o_push.beat0.edge_magnitude = sobm_pkg::magnitude(r_gx0, r_gy0);
        o_push.beat0.out_column     = r_col0;
        o_push.beat0.out_row        = r_row;
        o_push.beat0.frame_done     = 1'b0;
        o_push.beat1.edge_magnitude = sobm_pkg::magnitude(r_gx1, r_gy1);
        o_push.beat1.out_column     = r_col1;
        o_push.beat1.out_row        = r_row;
        o_push.beat1.frame_done     = r_done;
    end

endmodule

[sv/sobm_out_fifo.sv]
`timescale 1ns / 1ps
module sobm_out_fifo (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  sobm_pkg::t_push                  i_push,
    output logic [sobm_pkg::FIFO_CW-1:0]     o_count,
    sobm_out_if.source                       o_edge
);

    sobm_pkg::t_out_beat               r_mem [sobm_pkg::FIFO_DEPTH];
    logic [sobm_pkg::FIFO_AW-1:0]      r_wptr;
    logic [sobm_pkg::FIFO_AW-1:0]      r_rptr;
    logic [sobm_pkg::FIFO_CW-1:0]      r_count;
    logic [sobm_pkg::FIFO_CW-1:0]      n_count;
    logic [sobm_pkg::FIFO_AW-1:0]      wptr1;
    logic                              pop;

    assign pop   = o_edge.valid && o_edge.ready;
    assign wptr1 = i_push.v0 ? sobm_pkg::FIFO_AW'(r_wptr + 1'b1) : r_wptr;

    always_comb begin
        n_count = r_count + sobm_pkg::FIFO_CW'(i_push.v0) + sobm_pkg::FIFO_CW'(i_push.v1)
                  - sobm_pkg::FIFO_CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_mem[r_wptr] <= i_push.beat0;
        end
        if (i_push.v1) begin
            r_mem[wptr1] <= i_push.beat1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= i_push.v1 ? sobm_pkg::FIFO_AW'(wptr1 + 1'b1) : wptr1;
            r_count <= n_count;
            if (pop) begin
                r_rptr <= sobm_pkg::FIFO_AW'(r_rptr + 1'b1);
            end
        end
    end

    assign o_edge.valid = (r_count != '0);
    assign o_edge.data  = r_mem[r_rptr];
    assign o_count      = r_count;

endmodule

[sv/sobel_edge_magnitude_stream_core.sv]
`timescale 1ns / 1ps
// Channel   Dir  Payload                                          Handshake
// i_pix     in   kind, pix_val                                    valid/ready
// o_edge    out  edge_magnitude, out_column, out_row, frame_done  valid/ready
// i_cfg_*   in   index 0 line length, index 1 frame rows          write enable
//
// One beat per clock while i_pix.ready is high; results pass s1 and gradient registers.
// The line stores are a memory pair with one read and one write port, read at the
// current column; a read in the cycle that writes the same entry is forwarded.
// Output runs through an 8-deep FIFO; i_pix.ready drops only when it plus the
// in-flight results could overflow it. Reset clears counters and window, no memory sweep.
module sobel_edge_magnitude_stream_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    sobm_in_if.sink                       i_pix,
    sobm_out_if.source                    o_edge,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [sobm_pkg::CFG_W-1:0]    i_cfg_data
);

    logic [sobm_pkg::CFG_W-1:0]   r_width;
    logic [sobm_pkg::CFG_W-1:0]   r_height;
    logic [sobm_pkg::COL_W-1:0]   r_col;
    logic [sobm_pkg::ROW_W-1:0]   r_row;
    logic                         r_s1_valid;
    sobm_pkg::t_s1_item           r_s1;
    sobm_pkg::t_s1_item           n_s1;

    logic [sobm_pkg::CFG_W-1:0]   w_eff;
    logic [sobm_pkg::CFG_W-1:0]   h_eff;
    logic                         flushing;
    logic                         row_end;
    logic                         take;
    logic [sobm_pkg::FIFO_CW-1:0] fifo_count;
    logic [sobm_pkg::FIFO_CW+1:0] reserved;
    logic [sobm_pkg::PIX_W-1:0]   older_q;
    logic [sobm_pkg::PIX_W-1:0]   newer_q;
    sobm_pkg::t_line_wr           line_wr;
    sobm_pkg::t_push              push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= sobm_pkg::CFG_W'(240);
            r_height <= sobm_pkg::CFG_W'(240);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sobm_pkg::CFG_LINE_LEN:   r_width  <= i_cfg_data;
                sobm_pkg::CFG_FRAME_ROWS: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_eff = (r_width == '0) ? sobm_pkg::CFG_W'(1) :
                (r_width > sobm_pkg::W_MAX) ? sobm_pkg::W_MAX : r_width;
        h_eff = (r_height == '0) ? sobm_pkg::CFG_W'(1) :
                (r_height > sobm_pkg::H_MAX) ? sobm_pkg::H_MAX : r_height;
    end

    assign flushing = (r_row >= h_eff);
    assign row_end  = (sobm_pkg::CFG_W'(r_col) + 1'b1 >= w_eff);

    // worst case two results per item still in flight
    assign reserved = (sobm_pkg::FIFO_CW+2)'(fifo_count)
                    + (sobm_pkg::FIFO_CW+2)'(push.v0)
                    + (sobm_pkg::FIFO_CW+2)'(push.v1)
                    + (sobm_pkg::FIFO_CW+2)'({r_s1_valid, 1'b0});
    assign i_pix.ready = (reserved <= (sobm_pkg::FIFO_CW+2)'(sobm_pkg::FIFO_DEPTH - 2));

    // a pixel in the flush row or a flush inside the frame is dropped
    assign take = i_pix.valid && i_pix.ready
               && ((i_pix.data.kind == sobm_pkg::KIND_FLUSH) == flushing);

    always_comb begin
        n_s1.has_row1 = (r_row != '0);
        n_s1.has_row2 = (r_row >= sobm_pkg::ROW_W'(2));
        n_s1.flushing = flushing;
        n_s1.row_end  = row_end;
        n_s1.col      = r_col;
        n_s1.out_row  = 8'(r_row - 1'b1);
        n_s1.pixel    = i_pix.data.pix_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= take;
            if (take) begin
                if (row_end) begin
                    r_col <= '0;
                    r_row <= flushing ? '0 : sobm_pkg::ROW_W'(r_row + 1'b1);
                end else begin
                    r_col <= sobm_pkg::COL_W'(r_col + 1'b1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1 <= n_s1;
    end

    sobm_line_buf u_line_buf (
        .i_clk     (i_clk),
        .i_rd_addr (r_col),
        .i_wr      (line_wr),
        .o_older   (older_q),
        .o_newer   (newer_q)
    );

    sobm_grad u_grad (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s1_valid (r_s1_valid),
        .i_s1       (r_s1),
        .i_older    (older_q),
        .i_newer    (newer_q),
        .o_wr       (line_wr),
        .o_push     (push)
    );

    sobm_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_count (fifo_count),
        .o_edge  (o_edge)
    );

endmodule
